// ===== src/packed_value_bit_packer_defines.svh =====
// Assertion helpers for the bit packer.
`ifndef PACKED_VALUE_BIT_PACKER_DEFINES_SVH
`define PACKED_VALUE_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PVBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvbp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PVBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvbp: next-cycle check failed");

`endif

// ===== src/pvbp_pkg.sv =====
package pvbp_pkg;

    // Widths fixed by the field definitions
    localparam int PVBP_COUNT_BITS  = 32;
    localparam int PVBP_WIDTH_W     = 7;
    localparam int PVBP_VALUE_W     = 64;
    localparam int PVBP_BYTES_W     = 4;   // 0..8 bytes per item
    localparam int PVBP_STATUS_W    = 3;
    localparam int PVBP_CFG_DATA_W  = 32;
    localparam int PVBP_QUEUE_DEPTH = 2;

    // Status codes
    localparam logic [PVBP_STATUS_W-1:0] PVBP_ST_OK       = 3'd0;
    localparam logic [PVBP_STATUS_W-1:0] PVBP_ST_PAST_END = 3'd1;
    localparam logic [PVBP_STATUS_W-1:0] PVBP_ST_BAD_CNT  = 3'd2;
    localparam logic [PVBP_STATUS_W-1:0] PVBP_ST_FINISHED = 3'd3;
    localparam logic [PVBP_STATUS_W-1:0] PVBP_ST_BAD_W    = 3'd4;

    // Configuration register indexes
    localparam logic PVBP_REG_BITS_PER_VALUE = 1'b0;
    localparam logic PVBP_REG_VALUE_COUNT    = 1'b1;

    // Input actions
    localparam logic PVBP_ACT_ADD    = 1'b0;
    localparam logic PVBP_ACT_FINISH = 1'b1;

    // One queued job: bytes to send (lowest first), how many, and status
    typedef struct packed {
        logic [PVBP_VALUE_W-1:0]  word;
        logic [PVBP_BYTES_W-1:0]  nbytes;
        logic [PVBP_STATUS_W-1:0] status;
    } job_t;

    function automatic logic width_ok(input logic [PVBP_WIDTH_W-1:0] w);
        logic ok;
        case (w) inside
            7'd0, 7'd1, 7'd2, 7'd4, 7'd8, 7'd12, 7'd16, 7'd20,
            7'd24, 7'd28, 7'd32, 7'd40, 7'd48, 7'd56, 7'd64: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Zero bytes appended after the partial byte on finish
    function automatic logic [1:0] pad_bytes(input logic [PVBP_WIDTH_W-1:0] w);
        logic [PVBP_WIDTH_W-1:0] pad;
        logic [PVBP_WIDTH_W:0]   rounded;
        if (w > 7'd32) begin
            pad = 7'd64 - w;
        end else if (w > 7'd16) begin
            pad = 7'd32 - w;
        end else if (w > 7'd8) begin
            pad = 7'd16 - w;
        end else begin
            pad = '0;
        end
        rounded = {1'b0, pad} + 8'd7;
        return rounded[4:3];
    endfunction

endpackage

// ===== src/packed_value_bit_packer.sv =====
// Channel  | Direction | Payload                                  | Handshake
// ---------+-----------+------------------------------------------+---------------------
// s_       | in        | tdata value[63:0], tuser action          | s_tvalid / s_tready
// m_       | out       | tdata out_byte, tuser {status,byte_valid}| m_tvalid / m_tready
//          |           | tlast last                               |
// cfg_     | in        | cfg_index, cfg_data                      | cfg_valid / cfg_ready
//
// An item is classified and its bytes computed in the cycle it is accepted, then
// queued (two jobs deep); the serializer sends one result per cycle while m_tready
// is high, so an item gives max(1, bytes released) results, at most eight.
// Input is taken every cycle while the queue has room, independent of m_tready.
// Synchronous active-low reset clears stream state, configuration and the queue.
// Configuration writes are always accepted and apply to the next item.
module packed_value_bit_packer #(
    parameter int COUNT_BITS = pvbp_pkg::PVBP_COUNT_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_index,
    input  logic [pvbp_pkg::PVBP_CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pvbp_pkg::PVBP_VALUE_W-1:0]    s_tdata,   // [63:0] value
    input  logic [0:0]                           s_tuser,   // [0] action
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // [7:0] out_byte
    output logic [3:0]                           m_tuser,   // [0] byte_valid, [3:1] status
    output logic                                 m_tlast
);
    import pvbp_pkg::*;

    `include "packed_value_bit_packer_defines.svh"

    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    job_t push_job;
    job_t head_job;
    logic byte_valid;
    logic [PVBP_STATUS_W-1:0] status;

    assign cfg_ready = 1'b1;
    assign m_tuser   = {status, byte_valid};

    pvbp_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser[0]),
        .in_value   (s_tdata),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    pvbp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (queue_empty)
    );

    pvbp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_job       (head_job),
        .empty          (queue_empty),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (m_tdata),
        .out_byte_valid (byte_valid),
        .out_status     (status),
        .out_last       (m_tlast)
    );

    // An error result never carries a byte and ends its item
    `PVBP_ASSERT_NOW(a_err_single, aclk, aresetn, m_tvalid && (status != PVBP_ST_OK), !byte_valid && m_tlast)
    // A result without a byte is always the only one of its item
    `PVBP_ASSERT_NOW(a_empty_last, aclk, aresetn, m_tvalid && !byte_valid, m_tlast)
    // A queued job reaches the output stage in the next cycle when it is free
    `PVBP_ASSERT_NEXT(a_pickup, aclk, aresetn, !queue_empty && !m_tvalid, m_tvalid)

endmodule

// ===== src/pvbp_front.sv =====
module pvbp_front #(
    parameter int COUNT_BITS = pvbp_pkg::PVBP_COUNT_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [pvbp_pkg::PVBP_CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_action,
    input  logic [pvbp_pkg::PVBP_VALUE_W-1:0]   in_value,
    // to queue
    output logic                                push,
    output pvbp_pkg::job_t                      push_job,
    input  logic                                queue_full
);
    import pvbp_pkg::*;

    logic [PVBP_WIDTH_W-1:0]    bpv_reg;
    logic [PVBP_CFG_DATA_W-1:0] vcount_reg;
    logic [6:0]                 acc_reg;
    logic [2:0]                 cnt_reg;
    logic [COUNT_BITS-1:0]      taken_reg;
    logic                       done_reg;

    logic [6:0]                 acc_next;
    logic [2:0]                 cnt_next;
    logic [COUNT_BITS-1:0]      taken_next;
    logic                       done_next;

    logic [COUNT_BITS-1:0]      limit;
    logic [PVBP_VALUE_W-1:0]    mask;
    logic [PVBP_VALUE_W-1:0]    vmask;
    logic [PVBP_VALUE_W+6:0]    comb_bits;
    logic [6:0]                 bit_sum;
    logic [PVBP_BYTES_W-1:0]    add_bytes;
    logic [6:0]                 sel_base;
    logic                       accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;
    assign limit    = COUNT_BITS'(vcount_reg);

    // Splice the masked value above the pending bits
    assign mask      = bpv_reg[6] ? '1 : ((64'd1 << bpv_reg[5:0]) - 64'd1);
    assign vmask     = in_value & mask;
    assign comb_bits = ({7'd0, vmask} << cnt_reg) | {64'd0, acc_reg};
    assign bit_sum   = {4'd0, cnt_reg} + bpv_reg;
    assign add_bytes = bit_sum[6:3];
    assign sel_base  = {add_bytes, 3'b000};

    // Classify the item and build the job for the serializer
    always_comb begin
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        taken_next      = taken_reg;
        done_next       = done_reg;
        push_job.word   = '0;
        push_job.nbytes = '0;
        push_job.status = PVBP_ST_OK;
        if (!width_ok(bpv_reg)) begin
            push_job.status = PVBP_ST_BAD_W;
        end else if (in_action == PVBP_ACT_ADD) begin
            if (done_reg) begin
                push_job.status = PVBP_ST_FINISHED;
            end else if (taken_reg >= limit) begin
                push_job.status = PVBP_ST_PAST_END;
            end else begin
                push_job.word   = comb_bits[PVBP_VALUE_W-1:0];
                push_job.nbytes = add_bytes;
                acc_next        = comb_bits[sel_base +: 7];
                cnt_next        = bit_sum[2:0];
                taken_next      = taken_reg + COUNT_BITS'(1);
            end
        end else begin
            if (taken_reg != limit) begin
                push_job.status = PVBP_ST_BAD_CNT;
            end else if (done_reg) begin
                push_job.status = PVBP_ST_FINISHED;
            end else begin
                push_job.word   = {57'd0, acc_reg};
                push_job.nbytes = PVBP_BYTES_W'(cnt_reg != 3'd0)
                                + PVBP_BYTES_W'(pad_bytes(bpv_reg));
                acc_next        = '0;
                cnt_next        = '0;
                done_next       = 1'b1;
            end
        end
    end

    // Configuration and stream state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpv_reg    <= '0;
            vcount_reg <= '0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            taken_reg  <= '0;
            done_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == PVBP_REG_BITS_PER_VALUE) begin
                    bpv_reg <= cfg_data[PVBP_WIDTH_W-1:0];
                end else if (cfg_index == PVBP_REG_VALUE_COUNT) begin
                    vcount_reg <= cfg_data;
                end
            end
            if (accept) begin
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                taken_reg <= taken_next;
                done_reg  <= done_next;
            end
        end
    end

endmodule

// ===== src/pvbp_queue.sv =====
module pvbp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pvbp_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output pvbp_pkg::job_t head_job,
    output logic           empty
);
    import pvbp_pkg::*;

    localparam int PtrW = (PVBP_QUEUE_DEPTH > 1) ? $clog2(PVBP_QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(PVBP_QUEUE_DEPTH + 1);

    job_t            mem [PVBP_QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full     = (count_reg == CntW'(PVBP_QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(PVBP_QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + PtrW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(PVBP_QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + PtrW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CntW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

endmodule

// ===== src/pvbp_back.sv =====
module pvbp_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // from queue
    input  pvbp_pkg::job_t                       head_job,
    input  logic                                 empty,
    output logic                                 pop,
    // result stream
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [7:0]                           out_byte,
    output logic                                 out_byte_valid,
    output logic [pvbp_pkg::PVBP_STATUS_W-1:0]   out_status,
    output logic                                 out_last
);
    import pvbp_pkg::*;

    logic                     act_reg;
    logic [PVBP_VALUE_W-1:0]  word_reg;
    logic [PVBP_BYTES_W-1:0]  left_reg;
    logic [PVBP_STATUS_W-1:0] status_reg;
    logic                     xfer;

    assign out_valid      = act_reg;
    assign out_byte_valid = (left_reg != '0);
    assign out_byte       = out_byte_valid ? word_reg[7:0] : 8'd0;
    assign out_status     = status_reg;
    assign out_last       = (left_reg <= PVBP_BYTES_W'(1));
    assign xfer           = act_reg && out_ready;
    assign pop            = !empty && (!act_reg || (xfer && out_last));

    // Serialize one byte per transfer; load the next job behind the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
        end else if (pop) begin
            act_reg <= 1'b1;
        end else if (xfer && out_last) begin
            act_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            word_reg   <= head_job.word;
            left_reg   <= head_job.nbytes;
            status_reg <= head_job.status;
        end else if (xfer && !out_last) begin
            word_reg <= {8'd0, word_reg[PVBP_VALUE_W-1:8]};
            left_reg <= left_reg - PVBP_BYTES_W'(1);
        end
    end

endmodule

// ===== sim/packed_value_bit_packer_tb.sv =====
module packed_value_bit_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pvbp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 210;
    localparam int LONG_HOLD = 300;

    // One result transfer as seen on the m_ side
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic [2:0] status;
        logic       last;
    } beat_t;

    // Tracks the packed stream and the results it must produce
    class stream_scoreboard;
        logic [6:0]  width = '0;
        logic [31:0] total = '0;
        logic [31:0] taken = '0;
        logic [7:0]  partial = '0;
        int          held = 0;
        bit          closed = 1'b0;
        int          errors = 0;
        beat_t       pending_beats[$];

        function bit width_supported(logic [6:0] w);
            case (w)
                7'd0, 7'd1, 7'd2, 7'd4, 7'd8, 7'd12, 7'd16, 7'd20,
                7'd24, 7'd28, 7'd32, 7'd40, 7'd48, 7'd56, 7'd64: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // Zero bytes appended after the partial byte when the stream closes
        function int trailer_bytes(logic [6:0] w);
            case (w)
                7'd12, 7'd24, 7'd28, 7'd56: return 1;
                7'd20, 7'd48: return 2;
                7'd40: return 3;
                default: return 0;
            endcase
        endfunction

        // True when a finish now would really close the stream
        function bit finish_closes();
            return width_supported(width) && taken == total && !closed;
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == PVBP_REG_BITS_PER_VALUE) begin
                width = data[6:0];
            end else begin
                total = data;
            end
        endfunction

        // Work out the results of one accepted input transfer
        function void note_item(logic act, logic [63:0] val);
            beat_t      beats[$];
            logic [2:0] err;
            logic [63:0] bits;
            int         pad;
            err = PVBP_ST_OK;
            if (!width_supported(width)) begin
                err = PVBP_ST_BAD_W;
            end else if (act == PVBP_ACT_ADD) begin
                if (closed) begin
                    err = PVBP_ST_FINISHED;
                end else if (taken >= total) begin
                    err = PVBP_ST_PAST_END;
                end else begin
                    bits = (width == 7'd64) ? val : val & ((64'd1 << width) - 64'd1);
                    // shift in one bit at a time, LSB first
                    for (int i = 0; i < int'(width); i++) begin
                        partial[held] = bits[i];
                        held++;
                        if (held == 8) begin
                            beats.push_back('{partial, 1'b1, PVBP_ST_OK, 1'b0});
                            partial = '0;
                            held = 0;
                        end
                    end
                    taken = taken + 32'd1;
                end
            end else begin
                if (taken != total) begin
                    err = PVBP_ST_BAD_CNT;
                end else if (closed) begin
                    err = PVBP_ST_FINISHED;
                end else begin
                    if (held != 0) beats.push_back('{partial, 1'b1, PVBP_ST_OK, 1'b0});
                    pad = trailer_bytes(width);
                    repeat (pad) beats.push_back('{8'h00, 1'b1, PVBP_ST_OK, 1'b0});
                    partial = '0;
                    held = 0;
                    closed = 1'b1;
                end
            end
            // errors and empty transfers give one status-only result
            if (beats.size() == 0) beats.push_back('{8'h00, 1'b0, err, 1'b0});
            beats[beats.size()-1].last = 1'b1;
            foreach (beats[i]) pending_beats.push_back(beats[i]);
        endfunction

        function void note_diff(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s differs, expected %0h, actual %0h",
                             $time, field, want, got);
            end
        endfunction

        function void check_beat(logic [7:0] data, logic has_byte, logic [2:0] status,
                                 logic last);
            beat_t want;
            if (pending_beats.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result, expected none, actual data %0h status %0d",
                             $time, data, status);
                return;
            end
            want = pending_beats.pop_front();
            note_diff("out_byte", want.data, data);
            note_diff("byte_valid", 8'(want.has_byte), 8'(has_byte));
            note_diff("status", 8'(want.status), 8'(status));
            note_diff("last", 8'(want.last), 8'(last));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    stream_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int items_sent = 0;
    int cycles = 0;

    packed_value_bit_packer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tuser[0], m_tuser[3:1], m_tlast);
    end

    function automatic logic [63:0] rand_value();
        case ($urandom_range(9))
            0: return '1;
            1: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [6:0] rand_width(stream_scoreboard board);
        logic [6:0] w;
        w = 7'($urandom_range(127));
        while (!board.width_supported(w)) w = 7'($urandom_range(127));
        return w;
    endfunction

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
        endcase
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one input transfer; s_tvalid stays high for a following item
    task automatic send_item(logic act, logic [63:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(act, val);
        items_sent++;
    endtask

    // Stop sending and wait for every expected result
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int         seg;
        int         n;
        logic [6:0] w;
        logic [6:0] sweep[10];
        sweep = '{7'd2, 7'd4, 7'd8, 7'd16, 7'd20, 7'd24, 7'd28, 7'd32, 7'd48, 7'd56};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: count zero makes an add run past the end
        write_reg(PVBP_REG_VALUE_COUNT, 32'd0);
        send_item(PVBP_ACT_ADD, 64'h1234_5678_9ABC_DEF0);
        wait_idle();

        // Unsupported widths reject both actions
        write_reg(PVBP_REG_BITS_PER_VALUE, 32'd127);
        send_item(PVBP_ACT_ADD, '1);
        send_item(PVBP_ACT_FINISH, '0);
        wait_idle();
        write_reg(PVBP_REG_BITS_PER_VALUE, 32'd3);
        send_item(PVBP_ACT_ADD, 64'h5);
        wait_idle();

        // Width zero stores nothing but still counts
        write_reg(PVBP_REG_VALUE_COUNT, 32'hFFFF_FFFF);
        write_reg(PVBP_REG_BITS_PER_VALUE, 32'd0);
        send_item(PVBP_ACT_ADD, '1);
        wait_idle();

        // Single bits with junk above the width
        write_reg(PVBP_REG_BITS_PER_VALUE, 32'd1);
        send_item(PVBP_ACT_ADD, '1);
        send_item(PVBP_ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(PVBP_ACT_ADD, 64'h8000_0000_0000_0001);
        wait_idle();

        // Full-width values release eight bytes with bits pending
        write_reg(PVBP_REG_BITS_PER_VALUE, 32'd64);
        send_item(PVBP_ACT_ADD, '1);
        send_item(PVBP_ACT_ADD, '0);
        wait_idle();

        write_reg(PVBP_REG_BITS_PER_VALUE, 32'd12);
        send_item(PVBP_ACT_ADD, '1);
        send_item(PVBP_ACT_ADD, 64'hFFFF_FFFF_FFFF_FABC);
        wait_idle();

        // Finish before the count is reached
        write_reg(PVBP_REG_BITS_PER_VALUE, 32'd40);
        send_item(PVBP_ACT_ADD, rand_value());
        send_item(PVBP_ACT_FINISH, rand_value());
        wait_idle();

        // Remaining supported widths
        foreach (sweep[i]) begin
            write_reg(PVBP_REG_BITS_PER_VALUE, 32'(sweep[i]));
            send_item(PVBP_ACT_ADD, rand_value());
            wait_idle();
        end

        // Random segments, each with its own width, count and idling
        seg = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wait_idle();
            set_idling(seg % 4);
            if ($urandom_range(9) == 0) begin
                w = 7'($urandom_range(127));
                while (sb.width_supported(w)) w = 7'($urandom_range(127));
            end else begin
                w = rand_width(sb);
            end
            write_reg(PVBP_REG_BITS_PER_VALUE, 32'(w));
            if ($urandom_range(3) == 0)
                write_reg(PVBP_REG_VALUE_COUNT, sb.taken + 32'($urandom_range(5)));
            else
                write_reg(PVBP_REG_VALUE_COUNT, 32'hFFFF_FFFF);
            n = $urandom_range(4, 14);
            // one segment runs into a long receiver hold-off
            if (seg == 5) begin
                hold_req++;
                n = 16;
            end
            repeat (n) begin
                if ($urandom_range(9) == 0 && !sb.finish_closes())
                    send_item(PVBP_ACT_FINISH, rand_value());
                else
                    send_item(PVBP_ACT_ADD, rand_value());
            end
            seg++;
        end
        wait_idle();

        // Close the stream, then try to use it again
        set_idling(3);
        write_reg(PVBP_REG_BITS_PER_VALUE, 32'(rand_width(sb)));
        write_reg(PVBP_REG_VALUE_COUNT, sb.taken);
        send_item(PVBP_ACT_FINISH, rand_value());
        send_item(PVBP_ACT_FINISH, rand_value());
        send_item(PVBP_ACT_ADD, rand_value());
        wait_idle();
        write_reg(PVBP_REG_VALUE_COUNT, 32'd0);
        send_item(PVBP_ACT_FINISH, rand_value());
        wait_idle();
        repeat (20) @(posedge aclk);

        if (sb.pending_beats.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     sb.pending_beats.size());
        end
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
